### rtl/ufqd_pkg.sv
`default_nettype none
package ufqd_pkg;

    localparam int BYTE_W        = 8;
    localparam int POS_W         = 12;
    localparam int MARK_W        = 3;
    localparam int CNT_W         = 5;
    localparam int OUT_TDATA_W   = 32;
    localparam int DEF_MAX_PAIRS = 16;
    localparam int DEF_MAX_LEN   = 4096;
    localparam int RES_DEPTH     = 3;

    // Characters with a meaning in a form body
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_ALPHA_OFS = 8'd55;  // 'A' - 10

    typedef enum logic [MARK_W-1:0] {
        MK_DATA  = 3'd0,
        MK_KEY   = 3'd1,
        MK_VAL   = 3'd2,
        MK_END   = 3'd3,
        MK_UNREC = 3'd4
    } t_mark;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_esc;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [POS_W-1:0]  out_pos;
        t_mark             mark;
        logic [CNT_W-1:0]  pair_count;
        logic              last_of_run;
    } t_result;

    // Digit value, wrapping modulo 256 for anything that is not an uppercase hex digit
    function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
        return (c <= CH_NINE) ? (c - CH_ZERO) : (c - CH_ALPHA_OFS);
    endfunction

endpackage
`default_nettype wire

### rtl/url_form_query_decoder_top.sv
`default_nettype none
// Form-body decoder: takes one raw byte per cycle on the slave stream and produces decoded
// bytes with their write positions on the master stream. A byte is registered on transfer,
// decoded from that register and its results (none, one, or two when the final byte also
// completes data) are written into a three-entry result queue, whose head drives the
// master stream; each result passes the input register and the queue before it is taken.
// Input is taken every cycle while the queue holds at most one result, which sustains one
// byte per cycle as long as the master side keeps up; the only item with two results is the
// final one, so the queue never limits the rate in steady state.
// After the final terminator all further input is taken and dropped until reset.
// The pair cap register may be written at any time the block is idle.
module url_form_query_decoder_top #(
    parameter int MAX_PAIRS = ufqd_pkg::DEF_MAX_PAIRS,
    parameter int MAX_LEN   = ufqd_pkg::DEF_MAX_LEN
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration: pair cap
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [ufqd_pkg::CNT_W-1:0]           i_cfg_data,
    // raw body bytes
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [ufqd_pkg::BYTE_W-1:0]          s_axis_tdata,  // in_byte
    input  wire                                  s_axis_tlast,  // last_byte
    // decoded bytes
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [ufqd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // out_byte, out_pos, pair_count
    output logic [ufqd_pkg::MARK_W-1:0]          m_axis_tuser,  // mark
    output logic                                 m_axis_tlast   // last_of_run
);
    import ufqd_pkg::*;

    localparam int PW      = $clog2(MAX_LEN);
    localparam int EXT_W   = PW + POS_W;
    localparam int CAP_LIM = (MAX_PAIRS > 31) ? 31 : MAX_PAIRS;
    localparam int QCNT_W  = $clog2(RES_DEPTH + 1);
    localparam logic [PW-1:0]    POS_LIMIT = PW'(MAX_LEN - 1);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(CAP_LIM);

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] p);
        return (p < POS_LIMIT) ? (p + PW'(1)) : p;
    endfunction

    function automatic logic [POS_W-1:0] to_out_pos(input logic [PW-1:0] p);
        logic [EXT_W-1:0] e;
        e = EXT_W'(p);
        return e[POS_W-1:0];
    endfunction

    // configuration
    logic [CNT_W-1:0] r_max_pairs;
    logic [CNT_W-1:0] cap;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // decoder state
    t_esc              r_esc, n_esc;
    logic [BYTE_W-1:0] r_high, n_high;
    logic [PW-1:0]     r_write_pos, n_write_pos;
    logic [CNT_W-1:0]  r_pairs, n_pairs;
    logic              r_stopped;

    // result queue
    t_result           r_fifo [RES_DEPTH];
    t_result           n_fifo [RES_DEPTH];
    logic [QCNT_W-1:0] r_count, n_count;

    logic              proc;
    logic              pop;
    logic              end_hit;
    logic              emit_a;
    logic [BYTE_W-1:0] a_byte;
    t_mark             a_mark;
    logic [1:0]        n_res;
    t_result           res0, res1;

    assign o_cfg_ready = 1'b1;
    assign cap = (r_max_pairs < CAP_MAX) ? r_max_pairs : CAP_MAX;

    assign pop  = (r_count != '0) && m_axis_tready;
    assign proc = r_in_valid && (r_count <= QCNT_W'(1));
    assign s_axis_tready = !r_in_valid || proc;

    assign end_hit = !r_stopped
                     && (r_in_last || (r_esc == ESC_NONE && r_in_byte == CH_NUL));

    // escape phase next state
    always_comb begin
        n_esc = r_esc;
        if (!r_stopped) begin
            if (end_hit) begin
                n_esc = ESC_NONE;
            end else begin
                case (r_esc)
                    ESC_HIGH: n_esc = ESC_LOW;
                    ESC_LOW:  n_esc = ESC_NONE;
                    default:  n_esc = (r_in_byte == CH_PCT) ? ESC_HIGH : ESC_NONE;
                endcase
            end
        end
    end

    // decode and results
    always_comb begin
        emit_a  = 1'b0;
        a_byte  = '0;
        a_mark  = MK_DATA;
        n_high  = r_high;
        n_pairs = r_pairs;
        if (!r_stopped) begin
            case (r_esc)
                ESC_HIGH: n_high = digit_value(r_in_byte);
                ESC_LOW: begin
                    emit_a = 1'b1;
                    a_byte = {r_high[3:0], 4'b0000} + digit_value(r_in_byte);
                end
                default: begin
                    case (r_in_byte)
                        CH_PLUS: begin
                            emit_a = 1'b1;
                            a_byte = CH_SPACE;
                        end
                        CH_AMP, CH_SEMI: begin
                            emit_a = 1'b1;
                            a_mark = (r_pairs < cap) ? MK_KEY : MK_UNREC;
                        end
                        CH_EQ: begin
                            emit_a = 1'b1;
                            a_mark = MK_VAL;
                            if (r_pairs < cap) begin
                                n_pairs = r_pairs + CNT_W'(1);
                            end
                        end
                        CH_PCT, CH_HASH, CH_NUL: ;
                        default: begin
                            emit_a = 1'b1;
                            a_byte = r_in_byte;
                        end
                    endcase
                end
            endcase
        end

        n_res = {1'b0, emit_a} + {1'b0, end_hit};

        res0.out_byte    = emit_a ? a_byte : '0;
        res0.out_pos     = to_out_pos(r_write_pos);
        res0.mark        = emit_a ? a_mark : MK_END;
        res0.pair_count  = n_pairs;
        res0.last_of_run = !(emit_a && end_hit);

        res1.out_byte    = '0;
        res1.out_pos     = to_out_pos(sat_inc(r_write_pos));
        res1.mark        = MK_END;
        res1.pair_count  = n_pairs;
        res1.last_of_run = 1'b1;

        case (n_res)
            2'd1:    n_write_pos = sat_inc(r_write_pos);
            2'd2:    n_write_pos = sat_inc(sat_inc(r_write_pos));
            default: n_write_pos = r_write_pos;
        endcase
    end

    // queue: shift out at the head, append behind what remains
    always_comb begin
        n_fifo  = r_fifo;
        n_count = r_count;
        if (pop) begin
            for (int i = 0; i < RES_DEPTH - 1; i++) begin
                n_fifo[i] = r_fifo[i+1];
            end
            n_count = r_count - QCNT_W'(1);
        end
        if (proc) begin
            for (int i = 0; i < RES_DEPTH; i++) begin
                if (n_res != 2'd0 && i == int'(n_count)) begin
                    n_fifo[i] = res0;
                end
                if (n_res == 2'd2 && i == int'(n_count) + 1) begin
                    n_fifo[i] = res1;
                end
            end
            n_count = n_count + QCNT_W'(n_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pairs <= CAP_MAX;
            r_in_valid  <= 1'b0;
            r_esc       <= ESC_NONE;
            r_high      <= '0;
            r_write_pos <= '0;
            r_pairs     <= '0;
            r_stopped   <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_pairs <= i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_esc       <= n_esc;
                r_high      <= n_high;
                r_write_pos <= n_write_pos;
                r_pairs     <= n_pairs;
                r_stopped   <= r_stopped | end_hit;
            end
            r_count <= n_count;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        r_fifo <= n_fifo;
    end

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = OUT_TDATA_W'({r_fifo[0].pair_count, r_fifo[0].out_pos,
                                         r_fifo[0].out_byte});
    assign m_axis_tuser  = r_fifo[0].mark;
    assign m_axis_tlast  = r_fifo[0].last_of_run;

endmodule
`default_nettype wire

### rtl/ufqd_checker.sv
`default_nettype none
module ufqd_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 m_axis_tvalid,
    input wire                                 m_axis_tready,
    input wire [ufqd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input wire [ufqd_pkg::MARK_W-1:0]          m_axis_tuser,
    input wire                                 m_axis_tlast
);
    import ufqd_pkg::*;

    // hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // the final terminator always closes the run of its input
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == MK_END |-> m_axis_tlast)
        else $error("final terminator without tlast");

    // every terminator carries a zero byte
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != MK_DATA |-> m_axis_tdata[BYTE_W-1:0] == '0)
        else $error("terminator with nonzero byte");

    // nothing follows the final terminator
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser == MK_END |=> !m_axis_tvalid)
        else $error("result after final terminator");

endmodule

bind url_form_query_decoder_top ufqd_checker u_ufqd_checker (.*);
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ufqd_pkg::*;

    localparam int LAST_POS     = DEF_MAX_LEN - 1;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AFTER   = 150;
    localparam int PHASE_ITEMS  = 56;
    localparam int DRAIN_CYCLES = 4;

    // Decoder state mirror plus the queue of decoded bytes still owed by the block
    class decode_scoreboard;
        t_result          decoded_q[$];
        logic [CNT_W-1:0] cap_reg;
        t_esc             esc;
        logic [BYTE_W-1:0] high_nib;
        logic [POS_W-1:0] wr_pos;
        logic [CNT_W-1:0] pairs;
        bit               body_done;
        int               errors;

        function new();
            cap_reg   = CNT_W'(DEF_MAX_PAIRS);
            esc       = ESC_NONE;
            high_nib  = '0;
            wr_pos    = '0;
            pairs     = '0;
            body_done = 1'b0;
            errors    = 0;
        endfunction

        function void set_cap(input logic [CNT_W-1:0] v);
            cap_reg = v;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function bit escape_idle();
            return esc == ESC_NONE;
        endfunction

        function int pair_limit();
            return (int'(cap_reg) > DEF_MAX_PAIRS) ? DEF_MAX_PAIRS : int'(cap_reg);
        endfunction

        function logic [BYTE_W-1:0] hex_weight(input logic [BYTE_W-1:0] c);
            logic [BYTE_W-1:0] w;
            if (c <= CH_NINE) w = c - CH_ZERO;
            else w = c - CH_ALPHA_OFS;
            return w;
        endfunction

        function void write_out(input logic [BYTE_W-1:0] b, input t_mark mk);
            t_result r;
            r.out_byte    = b;
            r.out_pos     = wr_pos;
            r.mark        = mk;
            r.pair_count  = pairs;
            r.last_of_run = 1'b0;
            decoded_q.push_back(r);
            if (wr_pos != POS_W'(LAST_POS)) wr_pos = wr_pos + 1'b1;
        endfunction

        // Advance the mirror by one accepted raw byte and queue what it writes
        function void decode_byte(input logic [BYTE_W-1:0] c, input logic lst);
            int  q_size0;
            bit  ends;
            q_size0 = decoded_q.size();
            ends    = lst;
            if (body_done) return;
            case (esc)
                ESC_HIGH: begin
                    high_nib = hex_weight(c);
                    esc = lst ? ESC_NONE : ESC_LOW;
                end
                ESC_LOW: begin
                    esc = ESC_NONE;
                    write_out({high_nib[3:0], 4'h0} + hex_weight(c), MK_DATA);
                end
                default: begin
                    case (c)
                        CH_PLUS: write_out(CH_SPACE, MK_DATA);
                        CH_PCT:  esc = lst ? ESC_NONE : ESC_HIGH;
                        CH_AMP, CH_SEMI:
                            write_out(CH_NUL, (int'(pairs) < pair_limit()) ? MK_KEY : MK_UNREC);
                        CH_EQ: begin
                            if (int'(pairs) < pair_limit()) pairs = pairs + 1'b1;
                            write_out(CH_NUL, MK_VAL);
                        end
                        CH_HASH: ;
                        CH_NUL:  ends = 1'b1;
                        default: write_out(c, MK_DATA);
                    endcase
                end
            endcase
            if (ends) begin
                esc = ESC_NONE;
                write_out(CH_NUL, MK_END);
                body_done = 1'b1;
            end
            if (decoded_q.size() > q_size0)
                decoded_q[decoded_q.size() - 1].last_of_run = 1'b1;
        endfunction

        function void check_decoded(input logic [OUT_TDATA_W-1:0] tdata,
                                    input logic [MARK_W-1:0] tuser, input logic tlast);
            t_result got;
            t_result want;
            logic [OUT_TDATA_W-1:0] pad;
            got.out_byte    = tdata[BYTE_W-1:0];
            got.out_pos     = tdata[BYTE_W +: POS_W];
            got.pair_count  = tdata[BYTE_W+POS_W +: CNT_W];
            got.mark        = t_mark'(tuser);
            got.last_of_run = tlast;
            pad = tdata >> (BYTE_W + POS_W + CNT_W);
            if (decoded_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: byte %h pos %0d mark %0d pairs %0d last %b",
                             got.out_byte, got.out_pos, got.mark, got.pair_count,
                             got.last_of_run);
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte || got.out_pos !== want.out_pos ||
                got.mark !== want.mark || got.pair_count !== want.pair_count ||
                got.last_of_run !== want.last_of_run || pad !== '0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected byte %h pos %0d mark %0d pairs %0d last %b,",
                             want.out_byte, want.out_pos, want.mark, want.pair_count,
                             want.last_of_run,
                             " got byte %h pos %0d mark %0d pairs %0d last %b pad %h",
                             got.out_byte, got.out_pos, got.mark,
                             got.pair_count, got.last_of_run, pad);
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CNT_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tready = 1'b0;
    wire                    cfg_ready;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire [MARK_W-1:0]       m_tuser;
    wire                    m_tlast;

    decode_scoreboard sb = new();
    bit  send_quiet = 1'b0;
    bit  recv_quiet = 1'b0;
    int  body_items = 0;
    int  idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    url_form_query_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),   // in_byte
        .s_axis_tlast  (s_tlast),   // last_byte
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),   // out_byte, out_pos, pair_count
        .m_axis_tuser  (m_tuser),   // mark
        .m_axis_tlast  (m_tlast)    // last_of_run
    );

    // Watchdog: stop when no transfer happens on any channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    function automatic int draw_gap(inout bit quiet);
        if ($urandom_range(0, 39) == 0) quiet = ~quiet;
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.decode_byte(b, lst);
        @(negedge i_clk);
    endtask

    // A NUL outside an escape would end the body early; swap it for a plain byte
    task automatic send_body_byte(input logic [BYTE_W-1:0] b);
        if (b == CH_NUL && sb.escape_idle()) b = 8'h01;
        send_byte(b, 1'b0);
        body_items++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_digit();
        case ($urandom_range(0, 3))
            0:       return CH_ZERO + BYTE_W'($urandom_range(0, 9));
            1:       return BYTE_W'($urandom_range(8'h41, 8'h46));
            2:       return BYTE_W'($urandom_range(8'h61, 8'h66));
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_alnum();
        case ($urandom_range(0, 2))
            0:       return BYTE_W'($urandom_range(8'h61, 8'h7a));
            1:       return BYTE_W'($urandom_range(8'h41, 8'h5a));
            default: return CH_ZERO + BYTE_W'($urandom_range(0, 9));
        endcase
    endfunction

    task automatic send_word(input int len);
        repeat (len) begin
            case ($urandom_range(0, 5))
                0: send_body_byte(CH_PLUS);
                1: begin
                    send_body_byte(CH_PCT);
                    send_body_byte(pick_digit());
                    send_body_byte(pick_digit());
                end
                default: send_body_byte(pick_alnum());
            endcase
        end
    endtask

    task automatic send_pair();
        send_word($urandom_range(1, 4));
        send_body_byte(CH_EQ);
        send_word($urandom_range(0, 5));
        if ($urandom_range(0, 7) == 0) send_body_byte(CH_HASH);
        send_body_byte($urandom_range(0, 1) ? CH_AMP : CH_SEMI);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
                0:       send_body_byte(BYTE_W'($urandom_range(0, 255)));
                1:       send_body_byte(CH_PCT);
                default: send_body_byte($urandom_range(0, 1) ? CH_HASH : CH_EQ);
            endcase
        end
    endtask

    // Drop valid, wait for every owed result, then let in-flight bytes settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cap(input logic [CNT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        sb.set_cap(v);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off so the block backs up
    initial begin : result_sink
        int  gap;
        int  seen;
        bit  held;
        seen = 0;
        held = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held && seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                gap = draw_gap(recv_quiet);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            sb.check_decoded(m_tdata, m_tuser, m_tlast);
            seen++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [BYTE_W-1:0] warmup_seq [0:23];
        logic [CNT_W-1:0]  caps [0:4];
        int                target;
        int                end_kind;

        warmup_seq = '{"k", CH_PLUS, CH_PCT, "4", "1", CH_PCT, "6", "a", CH_EQ,
                       CH_PCT, CH_AMP, CH_EQ, CH_SEMI, CH_HASH, 8'hFF, 8'h80,
                       CH_PCT, CH_NUL, CH_NUL, CH_AMP, CH_EQ, CH_PCT, "F", "F"};
        caps = '{5'd31, 5'd0, 5'd1, CNT_W'($urandom_range(0, 31)), 5'd16};

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening at the reset cap: escapes in both cases, terminators and
        // NUL taken as digits, dropped hash, top and bottom byte values
        foreach (warmup_seq[k]) send_body_byte(warmup_seq[k]);
        wait_drained();

        foreach (caps[p]) begin
            write_cap(caps[p]);
            target = body_items + PHASE_ITEMS;
            while (body_items < target) begin
                if ($urandom_range(0, 9) < 8) send_pair();
                else send_noise();
            end
            wait_drained();
        end

        repeat (40) begin
            if ($urandom_range(0, 9) == 0) send_pair();
            else send_body_byte(pick_alnum());
        end
        while (!sb.escape_idle()) send_body_byte("x");

        // One way of ending the body, chosen per run
        end_kind = $urandom_range(0, 5);
        case (end_kind)
            0: send_byte(CH_NUL, 1'b0);
            1: send_byte("z", 1'b1);
            2: send_byte(CH_PCT, 1'b1);
            3: begin
                send_body_byte(CH_PCT);
                send_byte("4", 1'b1);
            end
            4: send_byte(CH_HASH, 1'b1);
            default: begin
                send_body_byte(CH_PCT);
                send_body_byte("4");
                send_byte("1", 1'b1);
            end
        endcase

        // Everything after the final terminator is swallowed
        repeat (6) send_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_drained();
        repeat (10) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
